### sv/pkst_pkg.sv
// ----------------------------------------------------------------------------
// pkst_pkg: shared definitions for the prefix-k sum segment tree
// Field widths, function codes, the node and row layouts, and the token
// that walks down the chain of level cells.
// ----------------------------------------------------------------------------
package pkst_pkg;

	localparam int LEVELS    = 10;
	localparam int POSITIONS = 1 << LEVELS;
	localparam int FUNC_W    = 2;
	localparam int POS_W     = LEVELS;
	localparam int VAL_W     = 16;
	localparam int CNT_W     = 11;
	localparam int SUM_W     = 26;
	localparam int ADDR_W    = LEVELS - 1;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

	typedef enum logic [1:0] {
		OP_NOP    = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
	} node_t;

	// One memory row holds a pair of sibling nodes.
	typedef struct packed {
		node_t left;
		node_t right;
	} row_t;

	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  value;
		logic [CNT_W-1:0]  need;
		logic [SUM_W-1:0]  acc;
	} token_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] row;
	} clr_t;

endpackage

### sv/pkst_ram.sv
// ----------------------------------------------------------------------------
// pkst_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pkst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/pkst_cell.sv
// ----------------------------------------------------------------------------
// pkst_cell: one tree level of the segment tree
// Holds the sibling pairs of its level, steers the walking token left or
// right, updates the chosen node on insert and passes the token down.
// ----------------------------------------------------------------------------
module pkst_cell #(
	parameter int LEVEL = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pkst_pkg::token_t tok_in,
	input  pkst_pkg::clr_t   clr,
	output pkst_pkg::token_t tok_out
);

	localparam int ROWS    = 1 << (LEVEL - 1);
	localparam int AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int DIR_BIT = pkst_pkg::LEVELS - LEVEL;
	localparam bit LEAF    = (LEVEL == pkst_pkg::LEVELS);
	localparam logic [AW-1:0] ADDR_MASK = AW'(ROWS - 1);

	logic             valid_q;
	pkst_pkg::token_t tok_q;
	pkst_pkg::row_t   rd_row;
	pkst_pkg::row_t   wr_row;
	logic             go_left;
	logic             dir;
	logic [pkst_pkg::SUM_W-1:0] acc_step;
	logic [pkst_pkg::SUM_W-1:0] leaf_add;
	logic [pkst_pkg::CNT_W-1:0] need_step;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [$bits(pkst_pkg::row_t)-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_in;
	end

	// The left child's count decides the direction of a query.
	assign go_left = (rd_row.left.count >= tok_q.need);

	always_comb begin
		unique case (tok_q.op)
			pkst_pkg::OP_INSERT: dir = tok_q.position[DIR_BIT];
			pkst_pkg::OP_QUERY:  dir = !go_left;
			default:             dir = 1'b0;
		endcase
	end

	always_comb begin
		wr_row = rd_row;
		if (dir) begin
			wr_row.right.count = rd_row.right.count + pkst_pkg::CNT_W'(1);
			wr_row.right.sum   = rd_row.right.sum + pkst_pkg::SUM_W'(tok_q.value);
		end else begin
			wr_row.left.count  = rd_row.left.count + pkst_pkg::CNT_W'(1);
			wr_row.left.sum    = rd_row.left.sum + pkst_pkg::SUM_W'(tok_q.value);
		end
	end

	// Going right skips the whole left subtree.
	assign acc_step  = dir ? (tok_q.acc + rd_row.left.sum) : tok_q.acc;
	assign need_step = dir ? (tok_q.need - rd_row.left.count) : tok_q.need;
	assign leaf_add  = dir ? rd_row.right.sum : rd_row.left.sum;

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
		tok_out.addr  = {tok_q.addr[pkst_pkg::ADDR_W-2:0], dir};
		if (tok_q.op == pkst_pkg::OP_QUERY) begin
			tok_out.need = need_step;
			tok_out.acc  = LEAF ? (acc_step + leaf_add) : acc_step;
		end
	end

	assign we    = clr.en || (valid_q && (tok_q.op == pkst_pkg::OP_INSERT));
	assign waddr = clr.en ? (clr.row[AW-1:0] & ADDR_MASK) : tok_q.addr[AW-1:0];
	assign wdata = clr.en ? '0 : wr_row;

	pkst_ram #(
		.WIDTH ($bits(pkst_pkg::row_t)),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (tok_in.addr[AW-1:0]),
		.rdata (rd_row)
	);

endmodule

### sv/prefix_k_sum_segment_tree.sv
// ----------------------------------------------------------------------------
// prefix_k_sum_segment_tree: order-statistic prefix sum over 1024 slots
// Segment tree with a per-level chain of cells; clear, insert and query.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one result transfer. Insert, query and
// unused function codes walk the tree one level per cycle through a chain of
// ten level cells, each owning the node pairs of its level in a small RAM.
// Such an item's result is registered into the output register when its
// token leaves the last cell, and the next item is taken only after that, so
// only one item walks the tree at a time. Clear zeroes the tree with a sweep
// over 512 row addresses that writes one row of every level per cycle; its
// result is registered as the sweep ends, and the next item is taken only
// after the sweep. The same sweep runs after reset, with in_ready low
// throughout. The root count and sum live in flip-flops, so an insert that
// would overflow either one is dropped at entry. A query for zero entries
// returns zero, and one asking for more entries than are stored returns the
// total sum. The output register is backed by one holding stage, so a new
// item is taken while an earlier result still waits for its transfer;
// in_ready stays low while the holding stage is full.
// ----------------------------------------------------------------------------
module prefix_k_sum_segment_tree (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pkst_pkg::FUNC_W-1:0]   func,
	input  logic [pkst_pkg::POS_W-1:0]    position,
	input  logic [pkst_pkg::VAL_W-1:0]    value,
	input  logic [pkst_pkg::CNT_W-1:0]    count_wanted,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pkst_pkg::SUM_W-1:0]    prefix_sum
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_CLEAR = 3'b100
	} state_t;

	state_t                        state_q;
	logic [pkst_pkg::ADDR_W-1:0]   sweep_q;
	logic                          clr_item_q;
	logic [pkst_pkg::CNT_W-1:0]    root_count_q;
	logic [pkst_pkg::SUM_W-1:0]    root_sum_q;
	logic                          out_valid_q;
	logic [pkst_pkg::SUM_W-1:0]    out_sum_q;
	logic                          skid_valid_q;
	logic [pkst_pkg::SUM_W-1:0]    skid_sum_q;

	logic                          in_fire;
	logic                          sum_fits;
	logic                          insert_ok;
	logic                          sweep_last;
	logic                          done;
	logic [pkst_pkg::SUM_W-1:0]    done_sum;
	logic                          out_free;
	pkst_pkg::clr_t                clr;
	pkst_pkg::token_t              tok [pkst_pkg::LEVELS+1];

	assign in_ready  = (state_q == ST_IDLE) && !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign prefix_sum = out_sum_q;

	// An insert is dropped when the root count is full or the root sum would
	// overflow; the root bounds every node below it.
	assign sum_fits  = ({1'b0, root_sum_q} + {{(pkst_pkg::SUM_W + 1 - pkst_pkg::VAL_W){1'b0}},
		value}) <= {1'b0, pkst_pkg::SUM_MAX};
	assign insert_ok = (root_count_q != pkst_pkg::COUNT_MAX) && sum_fits;

	// The token entering the first cell comes straight from the input ports.
	always_comb begin
		tok[0]          = '0;
		tok[0].valid    = in_fire && (func != pkst_pkg::FUNC_CLEAR);
		tok[0].position = position;
		tok[0].value    = value;
		tok[0].need     = count_wanted;
		tok[0].op       = pkst_pkg::OP_NOP;
		if ((func == pkst_pkg::FUNC_INSERT) && insert_ok) begin
			tok[0].op = pkst_pkg::OP_INSERT;
		end else if ((func == pkst_pkg::FUNC_QUERY) && (count_wanted != '0)) begin
			tok[0].op = pkst_pkg::OP_QUERY;
		end
	end

	assign clr.en  = (state_q == ST_CLEAR);
	assign clr.row = sweep_q;

	for (genvar g = 1; g <= pkst_pkg::LEVELS; g++) begin : g_level
		pkst_cell #(
			.LEVEL (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[g-1]),
			.clr     (clr),
			.tok_out (tok[g])
		);
	end

	assign sweep_last = &sweep_q;

	// A clear's own result is issued when its sweep finishes; the sweep
	// after reset issues none.
	assign done     = ((state_q == ST_CLEAR) && sweep_last && clr_item_q)
		|| tok[pkst_pkg::LEVELS].valid;
	assign done_sum = tok[pkst_pkg::LEVELS].valid ? tok[pkst_pkg::LEVELS].acc : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			sweep_q      <= '0;
			clr_item_q   <= 1'b0;
			root_count_q <= '0;
			root_sum_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (func == pkst_pkg::FUNC_CLEAR) begin
							state_q      <= ST_CLEAR;
							sweep_q      <= '0;
							clr_item_q   <= 1'b1;
							root_count_q <= '0;
							root_sum_q   <= '0;
						end else begin
							state_q <= ST_WALK;
							if (tok[0].op == pkst_pkg::OP_INSERT) begin
								root_count_q <= root_count_q + pkst_pkg::CNT_W'(1);
								root_sum_q   <= root_sum_q + pkst_pkg::SUM_W'(value);
							end
						end
					end
				end
				ST_WALK: begin
					if (tok[pkst_pkg::LEVELS].valid) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + pkst_pkg::ADDR_W'(1);
					if (sweep_last) begin
						state_q    <= ST_IDLE;
						clr_item_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register with one holding stage behind it.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= done;
				end else begin
					out_valid_q <= done;
				end
			end else if (done) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_sum_q <= skid_sum_q;
				if (done) begin
					skid_sum_q <= done_sum;
				end
			end else if (done) begin
				out_sum_q <= done_sum;
			end
		end else if (done) begin
			skid_sum_q <= done_sum;
		end
	end

endmodule

### sv/pkst_checker.sv
// ----------------------------------------------------------------------------
// pkst_checker: port-level checks for the prefix-k sum segment tree
// Tracks items in flight and checks the transfers on both channels.
// ----------------------------------------------------------------------------
module pkst_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [pkst_pkg::SUM_W-1:0]  prefix_sum
);

	logic       in_fire;
	logic       out_fire;
	logic [1:0] pend_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Items taken in whose result transfer has not happened yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
		end
	end

	a_out_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("result offered with no item in flight");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items in flight");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> ((pend_q == 2'd0) || (pend_q == 2'd1)))
		else $error("input ready while two results are held");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("second item taken while one is still walking");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(prefix_sum)))
		else $error("stalled result changed or dropped");

endmodule

bind prefix_k_sum_segment_tree pkst_checker u_checker (.*);

### tb/tb_prefix_k_sum_segment_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_k_sum_segment_tree: self-checking regression for the segment tree
// Drives clear, insert, query and unused-code operations through the input handshake,
// predicts every prefix_sum with a flat per-slot shadow of the tree, and
// compares each result transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_prefix_k_sum_segment_tree;

	// Function code 3 is not decoded by the block; it must act as a no-op.
	localparam logic [pkst_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam int HALF_PERIOD_NS = 2;
	localparam int RESET_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 40;
	// Time limit for the whole run, well beyond the slowest legal run.
	localparam int LIMIT_NS       = 6_000_000;

	typedef struct {
		logic [pkst_pkg::FUNC_W-1:0] func;
		logic [pkst_pkg::POS_W-1:0]  position;
		logic [pkst_pkg::VAL_W-1:0]  value;
		logic [pkst_pkg::CNT_W-1:0]  count_wanted;
	} tree_op_t;

	logic                        clk    = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid;
	logic                        in_ready;
	logic [pkst_pkg::FUNC_W-1:0] func;
	logic [pkst_pkg::POS_W-1:0]  position;
	logic [pkst_pkg::VAL_W-1:0]  value;
	logic [pkst_pkg::CNT_W-1:0]  count_wanted;
	logic                        out_valid;
	logic                        out_ready;
	logic [pkst_pkg::SUM_W-1:0]  prefix_sum;

	// Operations waiting to be offered, and the sums the block owes us.
	tree_op_t                   pending_ops[$];
	logic [pkst_pkg::SUM_W-1:0] expected_sums[$];

	// Shadow of the tree, kept per slot. The tree walk always ends on the
	// leaf that holds the wanted entry, so summing whole slots in position
	// order until the wanted count is covered gives the same answer.
	int slot_count[pkst_pkg::POSITIONS];
	int slot_sum[pkst_pkg::POSITIONS];
	int tree_count;
	int tree_sum;

	// Rough occupied count as seen while queueing, used to aim queries.
	int staged_count;

	int   send_idle_pct;
	int   recv_stall_pct;
	logic pressure_on  = 1'b0;
	int   hold_left    = 0;
	logic hold_spent   = 1'b0;

	logic                       in_taken   = 1'b0;
	logic                       got_result = 1'b0;
	logic [pkst_pkg::SUM_W-1:0] got_sum;
	tree_op_t                   next_op;
	logic [pkst_pkg::SUM_W-1:0] want_sum;
	int                         mismatch_count;

	prefix_k_sum_segment_tree dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.position     (position),
		.value        (value),
		.count_wanted (count_wanted),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.prefix_sum   (prefix_sum)
	);

	always #(HALF_PERIOD_NS) clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow tree
	// ------------------------------------------------------------------------
	function automatic void clear_tree();
		foreach (slot_count[p]) begin
			slot_count[p] = 0;
			slot_sum[p]   = 0;
		end
		tree_count = 0;
		tree_sum   = 0;
	endfunction

	// The root count and sum must stay within their widths; an insert that
	// would break either limit leaves the tree untouched.
	function automatic void insert_slot(int p, int v);
		if (tree_count >= int'(pkst_pkg::COUNT_MAX))
			return;
		if (tree_sum + v > int'(pkst_pkg::SUM_MAX))
			return;
		slot_count[p] += 1;
		slot_sum[p]   += v;
		tree_count    += 1;
		tree_sum      += v;
	endfunction

	// Zero wanted gives zero. A slot reached with fewer entries wanted than
	// it holds still contributes its whole sum. Asking for more than is
	// occupied falls through the loop and yields the total.
	function automatic logic [pkst_pkg::SUM_W-1:0] prefix_of(int need);
		int acc = 0;
		if (need == 0)
			return '0;
		for (int p = 0; p < pkst_pkg::POSITIONS; p++) begin
			if (slot_count[p] != 0) begin
				acc += slot_sum[p];
				if (slot_count[p] >= need)
					return pkst_pkg::SUM_W'(acc);
				need -= slot_count[p];
			end
		end
		return pkst_pkg::SUM_W'(acc);
	endfunction

	function automatic void predict_step(logic [pkst_pkg::FUNC_W-1:0] f,
			logic [pkst_pkg::POS_W-1:0] p, logic [pkst_pkg::VAL_W-1:0] v,
			logic [pkst_pkg::CNT_W-1:0] k);
		logic [pkst_pkg::SUM_W-1:0] res = '0;
		case (f)
			pkst_pkg::FUNC_CLEAR:  clear_tree();
			pkst_pkg::FUNC_INSERT: insert_slot(int'(p), int'(v));
			pkst_pkg::FUNC_QUERY:  res = prefix_of(int'(k));
			default:               ;
		endcase
		expected_sums.insert(expected_sums.size(), res);
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------
	function automatic void queue_op(logic [pkst_pkg::FUNC_W-1:0] f,
			logic [pkst_pkg::POS_W-1:0] p, logic [pkst_pkg::VAL_W-1:0] v,
			logic [pkst_pkg::CNT_W-1:0] k);
		tree_op_t op;
		op.func         = f;
		op.position     = p;
		op.value        = v;
		op.count_wanted = k;
		pending_ops.insert(pending_ops.size(), op);
		if (f == pkst_pkg::FUNC_CLEAR)
			staged_count = 0;
		else if (f == pkst_pkg::FUNC_INSERT && staged_count < int'(pkst_pkg::COUNT_MAX))
			staged_count++;
	endfunction

	// Mostly inserts and queries so the tree grows deep between the rare
	// clears; queries are aimed around the current occupied count.
	task automatic queue_random(int n);
		int                          pick;
		logic [pkst_pkg::FUNC_W-1:0] f;
		logic [pkst_pkg::POS_W-1:0]  p;
		logic [pkst_pkg::VAL_W-1:0]  v;
		logic [pkst_pkg::CNT_W-1:0]  k;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 2)
				f = pkst_pkg::FUNC_CLEAR;
			else if (pick < 50)
				f = pkst_pkg::FUNC_INSERT;
			else if (pick < 96)
				f = pkst_pkg::FUNC_QUERY;
			else
				f = FUNC_UNUSED;
			// A quarter of the positions land on a handful of shared slots so
			// that repeated inserts pile up on the same leaf.
			if ($urandom_range(3) == 0)
				p = pkst_pkg::POS_W'($urandom_range(7) * 131);
			else
				p = pkst_pkg::POS_W'($urandom);
			case ($urandom_range(3))
				0:       v = $urandom_range(1) ? '1 : '0;
				1:       v = pkst_pkg::VAL_W'($urandom_range(255));
				default: v = pkst_pkg::VAL_W'($urandom);
			endcase
			pick = $urandom_range(9);
			if (pick < 7)
				k = pkst_pkg::CNT_W'($urandom_range(staged_count + 1));
			else if (pick < 9)
				k = pkst_pkg::CNT_W'($urandom);
			else
				k = pkst_pkg::CNT_W'(staged_count);
			queue_op(f, p, v, k);
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_sums.size() != 0
			|| got_result);
	endtask

	// ------------------------------------------------------------------------
	// Input driver: inputs change on the falling edge. A held item stays on
	// the bus untouched until its transfer has been seen on a rising edge.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_op      = pending_ops.pop_front();
				func         <= next_op.func;
				position     <= next_op.position;
				value        <= next_op.value;
				count_wanted <= next_op.count_wanted;
				in_valid     <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Every accepted input transfer is run through the shadow tree right away,
	// so expectations queue up in the order the block must answer them.
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			predict_step(func, position, value, count_wanted);
	end

	// ------------------------------------------------------------------------
	// Output side: the result transfer is captured on the rising edge and
	// checked on the falling edge, away from the rising edge where predictions
	// are added. out_ready is redrawn on every falling edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		got_result <= arst_n && out_valid && out_ready;
		got_sum    <= prefix_sum;
	end

	always @(negedge clk) begin
		if (got_result) begin
			if (expected_sums.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: prefix_sum=%0d",
					got_sum));
			end else begin
				want_sum = expected_sums.pop_front();
				if (got_sum !== want_sum)
					report_mismatch($sformatf("prefix_sum got %0d, want %0d",
						got_sum, want_sum));
			end
		end
		out_ready <= arst_n && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
	end

	// One long receiver hold-off, counted here, so the pipeline and the
	// output holding stage fill up and in_ready has to drop.
	always @(posedge clk) begin
		if (pressure_on && !hold_spent) begin
			hold_left  <= HOLD_CYCLES;
			hold_spent <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		in_valid       = 1'b0;
		func           = pkst_pkg::FUNC_CLEAR;
		position       = '0;
		value          = '0;
		count_wanted   = '0;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		staged_count   = 0;
		mismatch_count = 0;
		clear_tree();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: empty tree, unused code, both ends of every field, a
		// slot inserted twice, queries of zero, exact and too many entries.
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, '0);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, 11'd5);
		queue_op(FUNC_UNUSED, '1, '1, '1);
		queue_op(pkst_pkg::FUNC_INSERT, '0, '1, '0);
		queue_op(pkst_pkg::FUNC_INSERT, '1, 16'd1, '0);
		queue_op(pkst_pkg::FUNC_INSERT, 10'd512, 16'd100, '0);
		queue_op(pkst_pkg::FUNC_INSERT, 10'd512, 16'd200, '0);
		queue_op(pkst_pkg::FUNC_INSERT, 10'd511, 16'd7, '0);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, '0);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, 11'd1);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, 11'd2);
		// Stops inside the twice-filled slot and still takes its whole sum.
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, 11'd3);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, 11'd4);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, 11'd5);
		queue_op(pkst_pkg::FUNC_QUERY, '1, '1, 11'd1024);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, '1);
		queue_op(FUNC_UNUSED, '0, '0, '0);
		queue_op(pkst_pkg::FUNC_INSERT, '1, '0, '0);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, 11'd6);
		queue_op(pkst_pkg::FUNC_CLEAR, '1, '1, '1);
		queue_op(pkst_pkg::FUNC_QUERY, '0, '0, '1);
		queue_op(pkst_pkg::FUNC_INSERT, 10'h2AA, 16'h5555, 11'h555);
		queue_op(pkst_pkg::FUNC_INSERT, 10'h155, 16'hAAAA, 11'h2AA);
		queue_op(pkst_pkg::FUNC_QUERY, 10'h155, 16'hAAAA, 11'd1);
		queue_op(pkst_pkg::FUNC_QUERY, 10'h2AA, 16'h5555, 11'd2);
		wait_drained();

		// Random traffic under each idling pattern, starting with none.
		queue_random(110);
		wait_drained();
		send_idle_pct = 69;
		queue_random(110);
		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 69;
		queue_random(110);
		wait_drained();
		send_idle_pct  = 35;
		recv_stall_pct = 35;
		queue_random(110);
		wait_drained();

		// Back-pressure: the sender keeps offering while the receiver holds.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pressure_on    = 1'b1;
		queue_random(40);
		wait_drained();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_sums.size() == 0)
			$display("prefix_k_sum_segment_tree regression: pass");
		else
			$display("prefix_k_sum_segment_tree regression: fail");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d results outstanding", expected_sums.size());
		$display("prefix_k_sum_segment_tree regression: fail");
		$finish;
	end

endmodule
